/* src/mpq_pkg.sv */
// ---------------------------------------------------------------------------
// mpq_pkg: shared constants for the unsorted-list min priority queue
// field widths, request codes and the empty-queue minimum
// ---------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

  localparam int DATA_W       = 32;
  localparam int PRIO_W       = 16;
  localparam int COUNT_OUT_W  = 5;
  localparam int DEF_CAPACITY = 16;

  localparam logic signed [PRIO_W-1:0] EMPTY_MIN = 16'sh7FFF;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_DEL = 1'b1;

endpackage : mpq_pkg

`default_nettype wire

/* src/mpq_cmp_unit.sv */
// ---------------------------------------------------------------------------
// mpq_cmp_unit: shared priority compare unit
// equality test against the search key and a running minimum register
// ---------------------------------------------------------------------------
`default_nettype none

module mpq_cmp_unit (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    clr,
  input  wire                                    upd,
  input  wire  logic signed [mpq_pkg::PRIO_W-1:0] prio,
  input  wire  logic signed [mpq_pkg::PRIO_W-1:0] key,
  output logic                                   eq,
  output logic signed [mpq_pkg::PRIO_W-1:0]      min_nxt,
  output logic signed [mpq_pkg::PRIO_W-1:0]      min_r
);

  assign eq      = (prio == key);
  assign min_nxt = (prio < min_r) ? prio : min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= mpq_pkg::EMPTY_MIN;
    end else if (clr) begin
      min_r <= mpq_pkg::EMPTY_MIN;
    end else if (upd) begin
      min_r <= min_nxt;
    end
  end

endmodule : mpq_cmp_unit

`default_nettype wire

/* src/min_priority_queue_unsorted.sv */
// ---------------------------------------------------------------------------
// min_priority_queue_unsorted: bounded min priority queue, unsorted list
// entries kept oldest first in one memory; delete removes the oldest entry
// at the minimum priority, closes the gap and rescans for the new minimum
// ---------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser
//  in_     | in  | item_data, item_priority               | req_type
//  out_    | out | removed_data, removed_priority,        | -
//          |     | was_empty, was_full, entry_count       |
//
//  add, dropped add or delete on empty: handled in S_IDLE, result loaded from S_DONE
//  delete: S_SCAN, then S_SHIFT if later slots remain, result loaded from S_DONE; one slot a cycle
//  goes through the compare unit, first to find the match, then to move later slots down
//  one request at a time; a result waiting in the output register does not block the
//  next input transfer, only the next result load
//  synchronous reset empties the queue; memory contents need no clearing
// ---------------------------------------------------------------------------
`default_nettype none

module min_priority_queue_unsorted #(
  parameter int CAPACITY = mpq_pkg::DEF_CAPACITY
) (
  input  wire         clk,
  input  wire         rst_n,
  // in_tdata: [31:0] item_data, [47:32] item_priority
  input  wire  [47:0] in_tdata,
  // in_tuser: [0] req_type
  input  wire  [0:0]  in_tuser,
  input  wire         in_tvalid,
  output logic        in_tready,
  // out_tdata: [31:0] removed_data, [47:32] removed_priority, [48] was_empty,
  //            [49] was_full, [54:50] entry_count, [55] zero
  output logic [55:0] out_tdata,
  output logic        out_tvalid,
  input  wire         out_tready
);

  localparam int DW = mpq_pkg::DATA_W;
  localparam int PW = mpq_pkg::PRIO_W;
  localparam int EW = DW + PW;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] chk_r, chk_nxt;
  logic          force_r, force_nxt;
  logic signed [PW-1:0] cur_min_r, cur_min_nxt;

  logic signed [DW-1:0] res_data_r, res_data_nxt;
  logic signed [PW-1:0] res_prio_r, res_prio_nxt;
  logic                 res_empty_r, res_empty_nxt;
  logic                 res_full_r, res_full_nxt;

  logic        out_valid_r;
  logic [55:0] out_data_r;
  logic        out_load;

  // slot memory, {priority, data}
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  logic                 cu_clr, cu_upd, cu_eq;
  logic signed [PW-1:0] cu_min_nxt, cu_min_r;
  logic signed [PW-1:0] rd_prio;
  logic signed [DW-1:0] rd_data;

  logic [CW-1:0] count_m1;
  logic [CW-1:0] wr_idx;
  logic          last;
  logic          restart;

  logic                 in_req;
  logic signed [DW-1:0] in_data;
  logic signed [PW-1:0] in_prio;

  assign in_req  = in_tuser[0];
  assign in_data = in_tdata[DW-1:0];
  assign in_prio = in_tdata[EW-1:DW];

  assign rd_prio  = rd_q[EW-1:DW];
  assign rd_data  = rd_q[DW-1:0];
  assign count_m1 = count_r - CW'(1);
  assign wr_idx   = chk_r - CW'(1);
  assign last     = (chk_r == count_m1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[rd_addr];
  end

  mpq_cmp_unit u_cmp (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (cu_clr),
    .upd     (cu_upd),
    .prio    (rd_prio),
    .key     (cur_min_r),
    .eq      (cu_eq),
    .min_nxt (cu_min_nxt),
    .min_r   (cu_min_r)
  );

  assign in_tready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    chk_nxt       = chk_r;
    force_nxt     = force_r;
    cur_min_nxt   = cur_min_r;
    res_data_nxt  = res_data_r;
    res_prio_nxt  = res_prio_r;
    res_empty_nxt = res_empty_r;
    res_full_nxt  = res_full_r;
    mem_we        = 1'b0;
    mem_waddr     = wr_idx[AW-1:0];
    mem_wdata     = rd_q;
    cu_clr        = 1'b0;
    cu_upd        = 1'b0;
    restart       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_data_nxt  = '0;
          res_prio_nxt  = '0;
          res_empty_nxt = 1'b0;
          res_full_nxt  = 1'b0;
          state_nxt     = S_DONE;
          if (in_req == mpq_pkg::REQ_ADD) begin
            if (count_r >= CW'(CAPACITY)) begin
              res_full_nxt = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_r[AW-1:0];
              mem_wdata = {in_prio, in_data};
              count_nxt = count_r + CW'(1);
              if (in_prio < cur_min_r) begin
                cur_min_nxt = in_prio;
              end
            end
          end else if (count_r == '0) begin
            res_empty_nxt = 1'b1;
          end else begin
            // slot 0 is read at this edge
            cu_clr    = 1'b1;
            ptr_nxt   = CW'(1);
            chk_nxt   = '0;
            force_nxt = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (cu_eq || force_r) begin
          res_data_nxt = rd_data;
          res_prio_nxt = rd_prio;
          if (last) begin
            count_nxt   = count_m1;
            cur_min_nxt = cu_min_r;
            state_nxt   = S_DONE;
          end else begin
            ptr_nxt   = ptr_r + CW'(1);
            chk_nxt   = chk_r + CW'(1);
            state_nxt = S_SHIFT;
          end
        end else if (last) begin
          // no slot at the minimum: remove the oldest one instead
          restart   = 1'b1;
          force_nxt = 1'b1;
          cu_clr    = 1'b1;
          ptr_nxt   = CW'(1);
          chk_nxt   = '0;
        end else begin
          cu_upd  = 1'b1;
          ptr_nxt = ptr_r + CW'(1);
          chk_nxt = chk_r + CW'(1);
        end
      end

      S_SHIFT: begin
        // move the slot held in rd_q down by one
        mem_we = 1'b1;
        cu_upd = 1'b1;
        if (last) begin
          count_nxt   = count_m1;
          cur_min_nxt = cu_min_nxt;
          state_nxt   = S_DONE;
        end else begin
          ptr_nxt = ptr_r + CW'(1);
          chk_nxt = chk_r + CW'(1);
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (state_r == S_IDLE || restart) begin
      rd_addr = '0;
    end else begin
      rd_addr = ptr_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      ptr_r     <= '0;
      chk_r     <= '0;
      force_r   <= 1'b0;
      cur_min_r <= mpq_pkg::EMPTY_MIN;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      ptr_r     <= ptr_nxt;
      chk_r     <= chk_nxt;
      force_r   <= force_nxt;
      cur_min_r <= cur_min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_data_r  <= res_data_nxt;
    res_prio_r  <= res_prio_nxt;
    res_empty_r <= res_empty_nxt;
    res_full_r  <= res_full_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {1'b0, mpq_pkg::COUNT_OUT_W'(count_r), res_full_r, res_empty_r,
                     res_prio_r, res_data_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule : min_priority_queue_unsorted

`default_nettype wire
